// ===== src/lsfs_pkg.sv =====
// shared types and constants for the led strip frame serializer
`timescale 1ns / 1ps

package lsfs_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_PROTOCOL_MODE    = 3'd0;
    localparam logic [2:0] REG_LED_COUNT        = 3'd1;
    localparam logic [2:0] REG_WHITE_CAL_ENABLE = 3'd2;
    localparam logic [2:0] REG_WHITE_LIMIT      = 3'd3;
    localparam logic [2:0] REG_WHITE_RED        = 3'd4;
    localparam logic [2:0] REG_WHITE_GREEN      = 3'd5;
    localparam logic [2:0] REG_WHITE_BLUE       = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int COUNT_W     = 10;
    localparam int ENDN_W      = 6;
    localparam int IDX_W       = 6;

    // protocol modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_EXT   = 2'd1;
    localparam logic [1:0] MODE_APA   = 2'd2;

    // frame bytes
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_W = 8'h77;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] HDR_XOR    = 8'h55;
    localparam logic [7:0] MARK_BYTE  = 8'hFF;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [8:0] FLETCHER_MOD = 9'd255;

    // live configuration
    typedef struct packed {
        logic [1:0]         protocol_mode;
        logic [COUNT_W-1:0] led_count;
        logic               white_cal_enable;
        logic [7:0]         white_limit;
        logic [7:0]         white_red;
        logic [7:0]         white_green;
        logic [7:0]         white_blue;
    } lsfs_cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               first;
        logic               last;
        logic [1:0]         mode;
        logic [COUNT_W-1:0] cnt;
        logic [ENDN_W-1:0]  endn;
    } lsfs_job_t;

    // queue status
    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } lsfs_qstat_t;

    // sequencer phases
    typedef enum logic [6:0] {
        PH_HDR   = 7'b0000001,
        PH_START = 7'b0000010,
        PH_MARK  = 7'b0000100,
        PH_RGB   = 7'b0001000,
        PH_CAL   = 7'b0010000,
        PH_SUM   = 7'b0100000,
        PH_END   = 7'b1000000
    } lsfs_phase_t;

    // one fletcher step mod 255
    function automatic logic [7:0] lsfs_mod_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= FLETCHER_MOD) begin
            s = s - FLETCHER_MOD;
        end
        return s[7:0];
    endfunction

endpackage

// ===== src/lsfs_front.sv =====
// front part: accepts items, tracks frame position and classifies each item
`timescale 1ns / 1ps

module lsfs_front import lsfs_pkg::*; #(
    parameter int MAX_LEDS = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  lsfs_cfg_t   cfg,
    input  lsfs_qstat_t qstat,
    output logic        push,
    output lsfs_job_t   job
);

    localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_LEDS);

    logic [COUNT_W-1:0] led_position_reg;
    logic [COUNT_W-1:0] led_position_next;
    logic [COUNT_W-1:0] n_eff;
    logic [1:0]         mode_eff;
    logic [COUNT_W:0]   pos_plus;
    logic [COUNT_W:0]   n_round;
    logic [ENDN_W-1:0]  endn_raw;
    logic               is_last;

    assign s_ready = !qstat.full;
    assign push    = s_valid && s_ready;

    // clamp count to 1..MAX_LEDS and fold unused mode code into plain
    always_comb begin
        if (cfg.led_count == '0) begin
            n_eff = COUNT_W'(1);
        end else if (cfg.led_count > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = cfg.led_count;
        end
        mode_eff = (cfg.protocol_mode == MODE_EXT || cfg.protocol_mode == MODE_APA) ?
                   cfg.protocol_mode : MODE_PLAIN;
    end

    // last led and end byte count
    assign pos_plus = {1'b0, led_position_reg} + (COUNT_W+1)'(1);
    assign is_last  = pos_plus >= {1'b0, n_eff};
    assign n_round  = {1'b0, n_eff} + (COUNT_W+1)'(15);
    assign endn_raw = n_round[ENDN_W+3:4];

    // item descriptor
    always_comb begin
        job.red   = s_red;
        job.green = s_green;
        job.blue  = s_blue;
        job.first = (led_position_reg == '0);
        job.last  = is_last;
        job.mode  = mode_eff;
        job.cnt   = (mode_eff == MODE_APA) ? n_eff : n_eff - COUNT_W'(1);
        job.endn  = (endn_raw < ENDN_W'(4)) ? ENDN_W'(4) : endn_raw;
    end

    // frame position
    always_comb begin
        led_position_next = led_position_reg;
        if (push) begin
            led_position_next = is_last ? '0 : pos_plus[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_position_reg <= '0;
        end else begin
            led_position_reg <= led_position_next;
        end
    end

endmodule

// ===== src/lsfs_queue.sv =====
// two-entry item queue between front and back
`timescale 1ns / 1ps

module lsfs_queue import lsfs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  lsfs_job_t   push_job,
    input  logic        pop,
    output lsfs_job_t   head_job,
    output lsfs_qstat_t qstat
);

    lsfs_job_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign head_job    = entry_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);
    assign qstat.count = count_reg;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== src/lsfs_back.sv =====
// back part: byte sequencer, fletcher sums and output register
`timescale 1ns / 1ps

module lsfs_back import lsfs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  lsfs_cfg_t   cfg,
    input  lsfs_job_t   head_job,
    input  lsfs_qstat_t qstat,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_frame_end,
    output logic        m_run_last
);

    lsfs_job_t         cur_reg;
    lsfs_phase_t       phase_reg;
    lsfs_phase_t       phase_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              busy_reg;
    logic [7:0]        sum_first_reg;
    logic [7:0]        sum_second_reg;
    logic [7:0]        sum_first_upd;
    logic              m_valid_reg;
    logic [7:0]        m_out_byte_reg;
    logic              m_frame_end_reg;
    logic              m_run_last_reg;

    logic              advance;
    logic              job_done;
    logic              is_payload;
    logic              load;
    logic [7:0]        byte_val;
    logic [7:0]        cnt_hi;
    logic [7:0]        cnt_lo;
    lsfs_phase_t       load_phase;

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_out_byte_reg;
    assign m_frame_end = m_frame_end_reg;
    assign m_run_last  = m_run_last_reg;

    assign advance = busy_reg && (!m_valid_reg || m_ready);
    assign load    = !qstat.empty && (!busy_reg || (advance && job_done));
    assign pop     = load;

    assign cnt_hi = {6'd0, cur_reg.cnt[COUNT_W-1:8]};
    assign cnt_lo = cur_reg.cnt[7:0];

    // opening phase of a newly loaded item
    always_comb begin
        if (head_job.first) begin
            load_phase = PH_HDR;
        end else if (head_job.mode == MODE_APA) begin
            load_phase = PH_MARK;
        end else begin
            load_phase = PH_RGB;
        end
    end

    // current byte and phase sequencing
    always_comb begin
        byte_val   = ZERO_BYTE;
        job_done   = 1'b0;
        is_payload = 1'b0;
        phase_next = phase_reg;
        idx_next   = idx_reg + IDX_W'(1);
        unique case (phase_reg)
            PH_HDR: begin
                case (idx_reg)
                    6'd0: byte_val = CH_UPPER_A;
                    6'd1: byte_val = (cur_reg.mode == MODE_EXT) ? CH_LOWER_W : CH_LOWER_D;
                    6'd2: byte_val = (cur_reg.mode == MODE_EXT && cfg.white_cal_enable) ?
                                     CH_UPPER_A : CH_LOWER_A;
                    6'd3: byte_val = cnt_hi;
                    6'd4: byte_val = cnt_lo;
                    default: byte_val = cnt_hi ^ cnt_lo ^ HDR_XOR;
                endcase
                if (idx_reg == IDX_W'(5)) begin
                    phase_next = (cur_reg.mode == MODE_APA) ? PH_START : PH_RGB;
                    idx_next   = '0;
                end
            end
            PH_START: begin
                byte_val = ZERO_BYTE;
                if (idx_reg == IDX_W'(3)) begin
                    phase_next = PH_MARK;
                    idx_next   = '0;
                end
            end
            PH_MARK: begin
                byte_val   = MARK_BYTE;
                phase_next = PH_RGB;
                idx_next   = '0;
            end
            PH_RGB: begin
                is_payload = 1'b1;
                case (idx_reg)
                    6'd0:    byte_val = cur_reg.red;
                    6'd1:    byte_val = cur_reg.green;
                    default: byte_val = cur_reg.blue;
                endcase
                if (idx_reg == IDX_W'(2)) begin
                    idx_next = '0;
                    if (!cur_reg.last || cur_reg.mode == MODE_PLAIN) begin
                        job_done = 1'b1;
                    end else if (cur_reg.mode == MODE_EXT) begin
                        phase_next = cfg.white_cal_enable ? PH_CAL : PH_SUM;
                    end else begin
                        phase_next = PH_END;
                    end
                end
            end
            PH_CAL: begin
                is_payload = 1'b1;
                case (idx_reg)
                    6'd0:    byte_val = cfg.white_limit;
                    6'd1:    byte_val = cfg.white_red;
                    6'd2:    byte_val = cfg.white_green;
                    default: byte_val = cfg.white_blue;
                endcase
                if (idx_reg == IDX_W'(3)) begin
                    phase_next = PH_SUM;
                    idx_next   = '0;
                end
            end
            PH_SUM: begin
                byte_val = (idx_reg == '0) ? sum_first_reg : sum_second_reg;
                job_done = (idx_reg == IDX_W'(1));
            end
            PH_END: begin
                byte_val = ZERO_BYTE;
                job_done = (idx_reg == cur_reg.endn - ENDN_W'(1));
            end
            default: begin
                byte_val = ZERO_BYTE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_HDR;
            idx_reg   <= '0;
        end else if (load) begin
            busy_reg  <= 1'b1;
            phase_reg <= load_phase;
            idx_reg   <= '0;
        end else if (advance && job_done) begin
            busy_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= head_job;
        end
    end

    // fletcher sums, cleared at frame start
    assign sum_first_upd = lsfs_mod_add(sum_first_reg, byte_val);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_first_reg  <= '0;
            sum_second_reg <= '0;
        end else if (load && head_job.first) begin
            sum_first_reg  <= '0;
            sum_second_reg <= '0;
        end else if (advance && is_payload) begin
            sum_first_reg  <= sum_first_upd;
            sum_second_reg <= lsfs_mod_add(sum_second_reg, sum_first_upd);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_out_byte_reg  <= byte_val;
            m_run_last_reg  <= job_done;
            m_frame_end_reg <= job_done && cur_reg.last;
        end
    end

endmodule

// ===== src/led_strip_frame_serializer_unit.sv =====
// top level of the led strip frame serializer
//
// One item on the s_ channel carries the color of one LED (s_red, s_green,
// s_blue). The m_ channel returns the serial frame one byte at a time, with
// m_frame_end on the final byte of a frame and m_run_last on the last byte
// caused by the current input item. Registers are written over the cfg_
// channel (cfg_index, cfg_data), which is always ready; write them only while
// the block is idle.
// An item passes the queue, the current-item and the output registers.
// Throughput: one output byte per cycle from the back sequencer unless it is
// stalled; an item gives 3 bytes in plain and extended mode and 4 in APA102
// mode, plus 6 header bytes (and 4 start bytes in APA102) on the first LED and
// on the last LED calibration, sums (extended) or end zeros (APA102).
// A two-entry item queue sits between the front and the back, so input is
// taken while the back is still emitting bytes of earlier items.
// Reset clears the frame position, the sums, the queue and the output; the
// configuration returns to plain mode, one LED.
// When the receiver stalls, the output register holds its byte, the back
// sequencer waits, and s_ready drops once the queue is full.
`timescale 1ns / 1ps

module led_strip_frame_serializer_unit import lsfs_pkg::*; #(
    parameter int MAX_LEDS = 512
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_red,
    input  logic [7:0]             s_green,
    input  logic [7:0]             s_blue,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_out_byte,
    output logic                   m_frame_end,
    output logic                   m_run_last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    lsfs_cfg_t   cfg_reg;
    lsfs_cfg_t   cfg_next;
    lsfs_job_t   push_job;
    lsfs_job_t   head_job;
    lsfs_qstat_t qstat;
    logic        push;
    logic        pop;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_PROTOCOL_MODE:    cfg_next.protocol_mode    = cfg_data[1:0];
                REG_LED_COUNT:        cfg_next.led_count        = cfg_data[COUNT_W-1:0];
                REG_WHITE_CAL_ENABLE: cfg_next.white_cal_enable = cfg_data[0];
                REG_WHITE_LIMIT:      cfg_next.white_limit      = cfg_data[7:0];
                REG_WHITE_RED:        cfg_next.white_red        = cfg_data[7:0];
                REG_WHITE_GREEN:      cfg_next.white_green      = cfg_data[7:0];
                REG_WHITE_BLUE:       cfg_next.white_blue       = cfg_data[7:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.protocol_mode    <= MODE_PLAIN;
            cfg_reg.led_count        <= COUNT_W'(1);
            cfg_reg.white_cal_enable <= 1'b0;
            cfg_reg.white_limit      <= 8'd3;
            cfg_reg.white_red        <= 8'd255;
            cfg_reg.white_green      <= 8'd255;
            cfg_reg.white_blue       <= 8'd255;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept and classify
    lsfs_front #(
        .MAX_LEDS (MAX_LEDS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_red   (s_red),
        .s_green (s_green),
        .s_blue  (s_blue),
        .cfg     (cfg_reg),
        .qstat   (qstat),
        .push    (push),
        .job     (push_job)
    );

    // item queue
    lsfs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    // back: byte sequencer
    lsfs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .head_job    (head_job),
        .qstat       (qstat),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_frame_end (m_frame_end),
        .m_run_last  (m_run_last)
    );

    // a frame always ends on the last byte of an item
    a_frame_end_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_run_last)
        else $error("frame end without run end");

    // no output right after reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // queue never overfills, and a pop never hits an empty queue
    a_queue_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (qstat.count != 2'd3) && !(pop && qstat.empty))
        else $error("queue bound violated");

endmodule
